FILE: hw/rtl/flv_tag_deframer_defines.svh
`ifndef FLV_TAG_DEFRAMER_DEFINES_SVH
`define FLV_TAG_DEFRAMER_DEFINES_SVH

// checks a property that must hold every cycle out of reset
`define FLV_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("flv_tag_deframer check failed");

// checks the cycle after a condition, reset included
`define FLV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("flv_tag_deframer check failed");

`endif

FILE: hw/rtl/flv_pkg.sv
package flv_pkg;

  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 2;

  localparam logic OP_CLEAN = 1'b1;

  localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
  localparam logic [2:0] KIND_EMPTY      = 3'd1;
  localparam logic [2:0] KIND_BAD_SIG    = 3'd2;
  localparam logic [2:0] KIND_BAD_OFFSET = 3'd3;
  localparam logic [2:0] KIND_FIRST_SIZE = 3'd4;
  localparam logic [2:0] KIND_TRAILER    = 3'd5;
  localparam logic [2:0] KIND_FLAGS      = 3'd6;

  localparam logic [7:0] SIG_F     = 8'h46;
  localparam logic [7:0] SIG_L     = 8'h4C;
  localparam logic [7:0] SIG_V     = 8'h56;
  localparam logic [7:0] FLAG_MASK = 8'hF8;

  localparam logic [31:0] HDR_LEN     = 32'd9;
  localparam logic [31:0] TAG_HDR_LEN = 32'd11;
  localparam logic [31:0] SIZE_LEN    = 32'd4;

  typedef enum logic [5:0] {
    PH_FILE_HDR   = 6'b000001,
    PH_SKIP       = 6'b000010,
    PH_FIRST_SIZE = 6'b000100,
    PH_TAG_HDR    = 6'b001000,
    PH_PAYLOAD    = 6'b010000,
    PH_TRAILER    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } flv_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  tag_type;
    logic [23:0] tag_size;
    logic [31:0] tag_time;
    logic        first_byte;
    logic        last_byte;
  } flv_out_t;

  typedef struct packed {
    logic       is_clean;
    logic [7:0] data;
  } flv_cmd_t;

endpackage

FILE: hw/rtl/flv_front.sv
module flv_front #(
  parameter int DEPTH = flv_pkg::FQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  flv_pkg::flv_in_t  in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output flv_pkg::flv_cmd_t cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flv_pkg::flv_cmd_t mem_r [DEPTH];
  flv_pkg::flv_cmd_t cmd_in;
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              wr_en, rd_en;

  // classify the beat on the way in
  always_comb begin
    cmd_in.is_clean = (in_data.op == flv_pkg::OP_CLEAN);
    cmd_in.data     = in_data.data_byte;
  end

  assign full      = (count_r == CW'(DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: hw/rtl/flv_parser.sv
module flv_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  flv_pkg::flv_cmd_t cmd,
  input  logic              res_ready,
  output logic              res_valid,
  output flv_pkg::flv_out_t res
);

  flv_pkg::phase_t phase_r, phase_nxt;
  logic        check_r;
  logic        header_done_r, header_done_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] cnt_inc;
  logic [7:0]  b;
  logic [7:0]  want;
  logic        step;
  logic        last;

  function automatic flv_pkg::flv_out_t mk_res(
    input logic [2:0]  kind,
    input logic [7:0]  pb,
    input logic        tagf,
    input logic        first,
    input logic        lst,
    input logic [7:0]  ttype,
    input logic [23:0] tsize,
    input logic [31:0] ttime
  );
    flv_pkg::flv_out_t r;
    r.kind         = kind;
    r.payload_byte = pb;
    r.tag_type     = tagf ? ttype : 8'd0;
    r.tag_size     = tagf ? tsize : 24'd0;
    r.tag_time     = tagf ? ttime : 32'd0;
    r.first_byte   = first;
    r.last_byte    = lst;
    return r;
  endfunction

  assign cmd_ready = res_ready;
  assign step      = cmd_valid && res_ready;
  assign b         = cmd.data;
  assign cnt_inc   = cnt_r + 32'd1;

  always_comb begin
    phase_nxt       = phase_r;
    header_done_nxt = header_done_r;
    halted_nxt      = halted_r;
    cnt_nxt         = cnt_r;
    offset_nxt      = offset_r;
    type_nxt        = type_r;
    size_nxt        = size_r;
    time_nxt        = time_r;
    acc_nxt         = acc_r;
    res_valid       = 1'b0;
    res             = '0;
    last            = 1'b0;
    case (cnt_r[1:0])
      2'd0:    want = flv_pkg::SIG_F;
      2'd1:    want = flv_pkg::SIG_L;
      default: want = flv_pkg::SIG_V;
    endcase

    if (step) begin
      if (cmd.is_clean) begin
        halted_nxt = 1'b0;
        cnt_nxt    = '0;
        acc_nxt    = '0;
        phase_nxt  = header_done_r ? flv_pkg::PH_TAG_HDR : flv_pkg::PH_FILE_HDR;
      end else if (!halted_r) begin
        unique case (phase_r)
          flv_pkg::PH_FILE_HDR: begin
            cnt_nxt = cnt_inc;
            if (cnt_r <= 32'd2) begin
              if (b != want) begin
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res = mk_res(flv_pkg::KIND_BAD_SIG, 8'd0, 1'b0, 1'b0, 1'b0,
                             type_r, size_r, time_r);
              end
            end else if (cnt_r == 32'd4) begin
              if ((b & flv_pkg::FLAG_MASK) != 8'd0) begin
                res_valid = 1'b1;
                res = mk_res(flv_pkg::KIND_FLAGS, 8'd0, 1'b0, 1'b0, 1'b0,
                             type_r, size_r, time_r);
              end
            end else if (cnt_r >= 32'd5) begin
              offset_nxt = {offset_r[23:0], b};
              if (cnt_r == 32'd8) begin
                if (offset_nxt < flv_pkg::HDR_LEN) begin
                  halted_nxt = 1'b1;
                  res_valid  = 1'b1;
                  res = mk_res(flv_pkg::KIND_BAD_OFFSET, 8'd0, 1'b0, 1'b0, 1'b0,
                               type_r, size_r, time_r);
                end else begin
                  acc_nxt = '0;
                  if (offset_nxt == flv_pkg::HDR_LEN) begin
                    phase_nxt = flv_pkg::PH_FIRST_SIZE;
                    cnt_nxt   = '0;
                  end else begin
                    phase_nxt = flv_pkg::PH_SKIP;
                  end
                end
              end
            end
          end
          flv_pkg::PH_SKIP: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= offset_r) begin
              phase_nxt = flv_pkg::PH_FIRST_SIZE;
              cnt_nxt   = '0;
              acc_nxt   = '0;
            end
          end
          flv_pkg::PH_FIRST_SIZE: begin
            acc_nxt = {acc_r[23:0], b};
            cnt_nxt = cnt_inc;
            if (cnt_inc >= flv_pkg::SIZE_LEN) begin
              header_done_nxt = 1'b1;
              phase_nxt       = flv_pkg::PH_TAG_HDR;
              cnt_nxt         = '0;
              if (acc_nxt != 32'd0) begin
                res_valid = 1'b1;
                res = mk_res(flv_pkg::KIND_FIRST_SIZE, 8'd0, 1'b0, 1'b0, 1'b0,
                             type_r, size_r, time_r);
              end
            end
          end
          flv_pkg::PH_TAG_HDR: begin
            cnt_nxt = cnt_inc;
            case (cnt_r)
              32'd0:   type_nxt = b;
              32'd1:   size_nxt = {b, 16'h0000};
              32'd2:   size_nxt = size_r | {8'h00, b, 8'h00};
              32'd3:   size_nxt = size_r | {16'h0000, b};
              32'd4:   time_nxt = {8'h00, b, 16'h0000};
              32'd5:   time_nxt = time_r | {16'h0000, b, 8'h00};
              32'd6:   time_nxt = time_r | {24'h000000, b};
              32'd7:   time_nxt = time_r | {b, 24'h000000};
              default: ;
            endcase
            if (cnt_inc >= flv_pkg::TAG_HDR_LEN) begin
              cnt_nxt = '0;
              acc_nxt = '0;
              if (size_nxt == 24'd0) begin
                phase_nxt = flv_pkg::PH_TRAILER;
                res_valid = 1'b1;
                res = mk_res(flv_pkg::KIND_EMPTY, 8'd0, 1'b1, 1'b0, 1'b1,
                             type_nxt, size_nxt, time_nxt);
              end else begin
                phase_nxt = flv_pkg::PH_PAYLOAD;
              end
            end
          end
          flv_pkg::PH_PAYLOAD: begin
            last    = (cnt_inc >= {8'h00, size_r});
            cnt_nxt = cnt_inc;
            if (last) begin
              phase_nxt = flv_pkg::PH_TRAILER;
              cnt_nxt   = '0;
              acc_nxt   = '0;
            end
            res_valid = 1'b1;
            res = mk_res(flv_pkg::KIND_PAYLOAD, b, 1'b1, (cnt_r == 32'd0), last,
                         type_r, size_r, time_r);
          end
          flv_pkg::PH_TRAILER: begin
            acc_nxt = {acc_r[23:0], b};
            cnt_nxt = cnt_inc;
            if (cnt_inc >= flv_pkg::SIZE_LEN) begin
              phase_nxt = flv_pkg::PH_TAG_HDR;
              cnt_nxt   = '0;
              if (check_r && (acc_nxt != ({8'h00, size_r} + flv_pkg::TAG_HDR_LEN))) begin
                res_valid = 1'b1;
                res = mk_res(flv_pkg::KIND_TRAILER, 8'd0, 1'b1, 1'b0, 1'b0,
                             type_r, size_r, time_r);
              end
            end
          end
          default: begin
            phase_nxt = flv_pkg::PH_FILE_HDR;
            cnt_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= flv_pkg::PH_FILE_HDR;
      check_r       <= 1'b1;
      header_done_r <= 1'b0;
      halted_r      <= 1'b0;
      cnt_r         <= '0;
      acc_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      header_done_r <= header_done_nxt;
      halted_r      <= halted_nxt;
      cnt_r         <= cnt_nxt;
      acc_r         <= acc_nxt;
      if (cfg_we) begin
        check_r <= cfg_wdata;
      end
    end
  end

  // field registers are always written before they are read
  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
    type_r   <= type_nxt;
    size_r   <= size_nxt;
    time_r   <= time_nxt;
  end

endmodule

FILE: hw/rtl/flv_outq.sv
module flv_outq #(
  parameter int DEPTH = flv_pkg::OQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  flv_pkg::flv_out_t res,
  output logic              empty,
  input  logic              pop,
  output flv_pkg::flv_out_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  flv_pkg::flv_out_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              wr_en, rd_en, full;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign rd_en     = pop && !empty;
  // a beat leaving frees the slot in the same cycle
  assign res_ready = !full || rd_en;
  assign wr_en     = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

FILE: hw/rtl/flv_tag_deframer.sv
// a beat is stored in the byte queue, parsed, then its result stored in the result queue
// throughput: one input beat per cycle while full is low, at most one result beat per cycle
// the parser steps whenever the byte queue holds a beat and the result queue has room or pops
// reset (synchronous, rst_n low): both queues empty, parser back to the file header,
// check_trailer set to 1
module flv_tag_deframer #(
  parameter int FQ_DEPTH = flv_pkg::FQ_DEPTH,
  parameter int OQ_DEPTH = flv_pkg::OQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  flv_pkg::flv_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output flv_pkg::flv_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  flv_pkg::flv_cmd_t cmd;
  flv_pkg::flv_out_t res;
  logic              cmd_valid, cmd_ready;
  logic              res_valid, res_ready;

  flv_front #(
    .DEPTH (FQ_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  flv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  flv_outq #(
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/flv_checker.sv
`include "flv_tag_deframer_defines.svh"

module flv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              full,
  input logic              empty,
  input flv_pkg::flv_out_t out_data
);

  `FLV_ASSERT_NEXT(a_reset_clears, !rst_n, empty && !full)
  `FLV_ASSERT_IMPL(a_kind_range, !empty, out_data.kind <= flv_pkg::KIND_FLAGS)
  `FLV_ASSERT_IMPL(a_byte_only_payload, !empty && (out_data.kind != flv_pkg::KIND_PAYLOAD), out_data.payload_byte == 8'd0)
  `FLV_ASSERT_IMPL(a_marks_on_data, !empty && (out_data.first_byte || out_data.last_byte), out_data.kind == flv_pkg::KIND_PAYLOAD || out_data.kind == flv_pkg::KIND_EMPTY)
  `FLV_ASSERT_IMPL(a_empty_tag_marks, !empty && (out_data.kind == flv_pkg::KIND_EMPTY), out_data.last_byte && !out_data.first_byte)

endmodule

bind flv_tag_deframer flv_checker u_flv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .out_data (out_data)
);
